>>> design/bts_pkg.sv
// shared types, constants and the gamma table of the bilinear texture sampler
`default_nettype none
package bts_pkg;

  localparam int MAX_SIDE_LOG2_DEF       = 8;
  localparam int CHANNEL_BITS_DEF        = 16;
  localparam int PIXEL_FRACTION_BITS_DEF = 8;

  localparam int UV_FRAC_BITS = 16;
  localparam int COORD_W      = 26;
  localparam int FRAC_W       = 16;
  localparam int WGT_W        = 17;
  localparam int CFG_INDEX_W  = 2;

  localparam logic [2:0] MODE_WRITE_LIN  = 3'd0;
  localparam logic [2:0] MODE_WRITE_SRGB = 3'd1;
  localparam logic [2:0] MODE_READ       = 3'd2;
  localparam logic [2:0] MODE_PIXEL      = 3'd3;
  localparam logic [2:0] MODE_UV         = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] REG_TEX_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TEX_HEIGHT = 2'd1;

  typedef struct packed {
    logic       capture;
    logic       coord;
    logic       tap;
    logic [1:0] tap_idx;
    logic       acc_en;
    logic       round;
    logic       read_capture;
    logic       load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       out_busy;
  } dp_status_t;

  typedef logic [12:0] gamma_tab_t [256];

  // largest n with (2n-1)^5 * 255^11 <= 2^65 * i^11
  function automatic gamma_tab_t build_gamma();
    gamma_tab_t   tab;
    logic [159:0] rhs;
    logic [159:0] lhs;
    int           n;
    bit           more;
    n = 0;
    for (int i = 0; i < 256; i++) begin
      rhs = 160'd1;
      for (int k = 0; k < 11; k++) rhs = rhs * 160'(i);
      rhs = rhs << 65;
      more = 1'b1;
      while (more && n < 8192) begin
        lhs = 160'd1;
        for (int k = 0; k < 5; k++) lhs = lhs * 160'(2 * n + 1);
        for (int k = 0; k < 11; k++) lhs = lhs * 160'd255;
        if (lhs <= rhs) n++;
        else more = 1'b0;
      end
      tab[i] = 13'(n);
    end
    return tab;
  endfunction

  localparam gamma_tab_t GAMMA = build_gamma();

endpackage
`default_nettype wire

>>> design/bts_ctrl.sv
// sequencing state machine of the bilinear texture sampler
`default_nettype none
module bts_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire bts_pkg::dp_status_t status,
  output bts_pkg::dp_cmd_t        cmd
);
  import bts_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_COORD = 7'b0000010,
    S_TAP   = 7'b0000100,
    S_DRAIN = 7'b0001000,
    S_ROUND = 7'b0010000,
    S_READ  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t     state, state_next;
  logic [1:0] tap, tap_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    tap_next   = tap;
    cmd        = '0;
    cmd.tap_idx = tap;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_COORD;
        end
      end
      S_COORD: begin
        cmd.coord = 1'b1;
        tap_next  = 2'd0;
        if (status.mode == MODE_PIXEL || status.mode == MODE_UV) state_next = S_TAP;
        else if (status.mode == MODE_READ) state_next = S_READ;
        else state_next = S_DONE;
      end
      S_TAP: begin
        cmd.tap    = 1'b1;
        cmd.acc_en = (tap != 2'd0);
        tap_next   = tap + 2'd1;
        if (tap == 2'd3) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        cmd.acc_en = 1'b1;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round  = 1'b1;
        state_next = S_DONE;
      end
      S_READ: begin
        cmd.read_capture = 1'b1;
        state_next       = S_DONE;
      end
      S_DONE: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tap   <= 2'd0;
    end else begin
      state <= state_next;
      tap   <= tap_next;
    end
  end

endmodule
`default_nettype wire

>>> design/bts_datapath.sv
// texel memory, coordinate and weight arithmetic, accumulators and result register
`default_nettype none
module bts_datapath #(
  parameter int MAX_SIDE_LOG2       = bts_pkg::MAX_SIDE_LOG2_DEF,
  parameter int CHANNEL_BITS        = bts_pkg::CHANNEL_BITS_DEF,
  parameter int PIXEL_FRACTION_BITS = bts_pkg::PIXEL_FRACTION_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire bts_pkg::dp_cmd_t                 cmd,
  output bts_pkg::dp_status_t                   status,
  input  wire logic [2:0]                       mode,
  input  wire logic signed [15:0]               texel_x,
  input  wire logic signed [15:0]               texel_y,
  input  wire logic signed [23:0]               pos_x,
  input  wire logic signed [23:0]               pos_y,
  input  wire logic [15:0]                      red_in,
  input  wire logic [15:0]                      green_in,
  input  wire logic [15:0]                      blue_in,
  input  wire logic                             cfg_write,
  input  wire logic [bts_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [MAX_SIDE_LOG2:0]           cfg_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [15:0]                           red_out,
  output logic [15:0]                           green_out,
  output logic [15:0]                           blue_out,
  output logic                                  out_of_bounds
);
  import bts_pkg::*;

  localparam int L      = MAX_SIDE_LOG2;
  localparam int SIDE_W = L + 1;
  localparam int CH     = CHANNEL_BITS;
  localparam int PFB    = PIXEL_FRACTION_BITS;
  localparam int ADDR_W = 2 * L;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int W2_W   = 2 * WGT_W;
  localparam int ACC_W  = CH + W2_W + 2;
  localparam logic [SIDE_W-1:0] MAX_SIDE = SIDE_W'(1) << L;
  localparam logic [31:0] CHAN_MAX = 32'((64'd1 << CH) - 64'd1);

  function automatic logic in_tex(input logic signed [COORD_W-1:0] x,
                                  input logic signed [COORD_W-1:0] y,
                                  input logic [SIDE_W-1:0] w,
                                  input logic [SIDE_W-1:0] h);
    logic signed [COORD_W-1:0] ws;
    logic signed [COORD_W-1:0] hs;
    ws = $signed(COORD_W'(w));
    hs = $signed(COORD_W'(h));
    return (x >= 0) && (y >= 0) && (x < ws) && (y < hs);
  endfunction

  function automatic logic [CH-1:0] sat_chan(input logic [31:0] v);
    return (v > CHAN_MAX) ? CH'(CHAN_MAX) : CH'(v);
  endfunction

  function automatic logic [15:0] sat16(input logic [ACC_W-1:0] v);
    return (v > ACC_W'(16'hFFFF)) ? 16'hFFFF : v[15:0];
  endfunction

  // configuration
  logic [SIDE_W-1:0] tex_width, tex_height, cfg_val;
  always_comb begin
    if (cfg_data == '0) cfg_val = SIDE_W'(1);
    else if (cfg_data > MAX_SIDE) cfg_val = MAX_SIDE;
    else cfg_val = cfg_data;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width  <= MAX_SIDE;
      tex_height <= MAX_SIDE;
    end else if (cfg_write) begin
      if (cfg_index == REG_TEX_WIDTH) tex_width <= cfg_val;
      else if (cfg_index == REG_TEX_HEIGHT) tex_height <= cfg_val;
    end
  end

  // captured request
  logic [2:0]         mode_q;
  logic signed [15:0] tx_q, ty_q;
  logic signed [23:0] px_q, py_q;
  logic [15:0]        r_q, g_q, b_q;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q <= mode;
      tx_q   <= texel_x;
      ty_q   <= texel_y;
      px_q   <= pos_x;
      py_q   <= pos_y;
      r_q    <= red_in;
      g_q    <= green_in;
      b_q    <= blue_in;
    end
  end
  assign status.mode = mode_q;

  // coordinate stage
  logic signed [COORD_W-1:0] txe, tye, x0_c, y0_c, x0, y0;
  logic [FRAC_W-1:0]         fx_c, fy_c, u, v;
  logic [FRAC_W+SIDE_W-1:0]  sx, sy;
  logic [WGT_W-1:0]          one, wx0, wx1, wy0, wy1;
  logic                      uv, fb_uv, tex_ok;
  assign txe = COORD_W'(tx_q);
  assign tye = COORD_W'(ty_q);
  assign tex_ok = in_tex(txe, tye, tex_width, tex_height);
  assign uv = (mode_q == MODE_UV);
  assign u  = px_q[15:0];
  assign v  = 16'(~py_q[15:0]) + 16'd1;
  assign sx = (FRAC_W + SIDE_W)'(u) * (FRAC_W + SIDE_W)'(tex_width);
  assign sy = (FRAC_W + SIDE_W)'(v) * (FRAC_W + SIDE_W)'(tex_height);
  always_comb begin
    if (uv) begin
      x0_c = $signed(COORD_W'(sx >> UV_FRAC_BITS));
      y0_c = $signed(COORD_W'(sy >> UV_FRAC_BITS));
      fx_c = sx[FRAC_W-1:0];
      fy_c = sy[FRAC_W-1:0];
      one  = WGT_W'(1) << UV_FRAC_BITS;
    end else begin
      x0_c = COORD_W'(px_q >>> PFB);
      y0_c = COORD_W'(py_q >>> PFB);
      fx_c = FRAC_W'(px_q[PFB-1:0]);
      fy_c = FRAC_W'(py_q[PFB-1:0]);
      one  = WGT_W'(1) << PFB;
    end
  end

  // result staging
  logic [15:0] res_r, res_g, res_b;
  logic        res_oob;

  // taps
  logic signed [COORD_W-1:0] nx, ny;
  logic [WGT_W-1:0]          wxs, wys;
  logic [W2_W-1:0]           wq;
  logic                      tap_in;
  assign nx  = x0 + COORD_W'(cmd.tap_idx[0]);
  assign ny  = y0 + COORD_W'(cmd.tap_idx[1]);
  assign wxs = cmd.tap_idx[0] ? wx1 : wx0;
  assign wys = cmd.tap_idx[1] ? wy1 : wy0;

  // texel memory
  logic [3*CH-1:0]   mem [DEPTH];
  logic [3*CH-1:0]   rdata, wdata;
  logic [ADDR_W-1:0] addr;
  logic              we, srgb;
  assign srgb = (mode_q == MODE_WRITE_SRGB);
  assign we = cmd.coord && tex_ok && ((mode_q == MODE_WRITE_LIN) || srgb);
  assign addr = cmd.tap ? {ny[L-1:0], nx[L-1:0]} : {tye[L-1:0], txe[L-1:0]};
  assign wdata = srgb ?
    {sat_chan(32'(GAMMA[b_q[7:0]])), sat_chan(32'(GAMMA[g_q[7:0]])),
     sat_chan(32'(GAMMA[r_q[7:0]]))} :
    {sat_chan(32'(b_q)), sat_chan(32'(g_q)), sat_chan(32'(r_q))};
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

  // accumulation
  logic [ACC_W-1:0] acc_r, acc_g, acc_b, rnd_r, rnd_g, rnd_b, half;
  logic [ACC_W-1:0] prod_r, prod_g, prod_b;
  assign prod_r = tap_in ? ACC_W'(rdata[CH-1:0]) * ACC_W'(wq) : '0;
  assign prod_g = tap_in ? ACC_W'(rdata[2*CH-1:CH]) * ACC_W'(wq) : '0;
  assign prod_b = tap_in ? ACC_W'(rdata[3*CH-1:2*CH]) * ACC_W'(wq) : '0;
  assign half = fb_uv ? (ACC_W'(1) << (2 * UV_FRAC_BITS - 1))
                      : (ACC_W'(1) << (2 * PFB - 1));
  assign rnd_r = fb_uv ? (acc_r + half) >> (2 * UV_FRAC_BITS) : (acc_r + half) >> (2 * PFB);
  assign rnd_g = fb_uv ? (acc_g + half) >> (2 * UV_FRAC_BITS) : (acc_g + half) >> (2 * PFB);
  assign rnd_b = fb_uv ? (acc_b + half) >> (2 * UV_FRAC_BITS) : (acc_b + half) >> (2 * PFB);

  always_ff @(posedge clk) begin
    if (cmd.coord) begin
      x0      <= x0_c;
      y0      <= y0_c;
      wx0     <= one - WGT_W'(fx_c);
      wx1     <= WGT_W'(fx_c);
      wy0     <= one - WGT_W'(fy_c);
      wy1     <= WGT_W'(fy_c);
      fb_uv   <= uv;
      acc_r   <= '0;
      acc_g   <= '0;
      acc_b   <= '0;
      res_r   <= '0;
      res_g   <= '0;
      res_b   <= '0;
      res_oob <= (mode_q == MODE_WRITE_LIN || mode_q == MODE_WRITE_SRGB ||
                  mode_q == MODE_READ) && !tex_ok;
    end
    if (cmd.tap) begin
      wq     <= W2_W'(wxs) * W2_W'(wys);
      tap_in <= in_tex(nx, ny, tex_width, tex_height);
    end
    if (cmd.acc_en) begin
      acc_r <= acc_r + prod_r;
      acc_g <= acc_g + prod_g;
      acc_b <= acc_b + prod_b;
    end
    if (cmd.round) begin
      res_r <= sat16(rnd_r);
      res_g <= sat16(rnd_g);
      res_b <= sat16(rnd_b);
    end
    if (cmd.read_capture && !res_oob) begin
      res_r <= sat16(ACC_W'(rdata[CH-1:0]));
      res_g <= sat16(ACC_W'(rdata[2*CH-1:CH]));
      res_b <= sat16(ACC_W'(rdata[3*CH-1:2*CH]));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      red_out       <= res_r;
      green_out     <= res_g;
      blue_out      <= res_b;
      out_of_bounds <= res_oob;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.load_out) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end
  assign status.out_busy = out_valid && out_stall;

endmodule
`default_nettype wire

>>> design/bilinear_texture_sampler.sv
// top level of the bilinear texture sampler
// One request at a time. A texel write passes through the coordinate and
// hand-off states, a read also through a read state, and a bilinear or UV
// sample through the tap states: the four neighbours are fetched from the
// single-port texel memory one a cycle, followed by accumulate, rounding and
// hand-off steps. The result register frees the block as soon as its result
// is loaded. The texel memory is not cleared after reset; reading a texel
// never written returns arbitrary data. Configuration is always ready.
`default_nettype none
module bilinear_texture_sampler #(
  parameter int MAX_SIDE_LOG2       = bts_pkg::MAX_SIDE_LOG2_DEF,
  parameter int CHANNEL_BITS        = bts_pkg::CHANNEL_BITS_DEF,
  parameter int PIXEL_FRACTION_BITS = bts_pkg::PIXEL_FRACTION_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [2:0]                      mode,
  input  wire logic signed [15:0]              texel_x,
  input  wire logic signed [15:0]              texel_y,
  input  wire logic signed [23:0]              pos_x,
  input  wire logic signed [23:0]              pos_y,
  input  wire logic [15:0]                     red_in,
  input  wire logic [15:0]                     green_in,
  input  wire logic [15:0]                     blue_in,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [15:0]                          red_out,
  output logic [15:0]                          green_out,
  output logic [15:0]                          blue_out,
  output logic                                 out_of_bounds,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bts_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [MAX_SIDE_LOG2:0]          cfg_data
);
  import bts_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  bts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  bts_datapath #(
    .MAX_SIDE_LOG2       (MAX_SIDE_LOG2),
    .CHANNEL_BITS        (CHANNEL_BITS),
    .PIXEL_FRACTION_BITS (PIXEL_FRACTION_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .mode          (mode),
    .texel_x       (texel_x),
    .texel_y       (texel_y),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .red_in        (red_in),
    .green_in      (green_in),
    .blue_in       (blue_in),
    .cfg_write     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .red_out       (red_out),
    .green_out     (green_out),
    .blue_out      (blue_out),
    .out_of_bounds (out_of_bounds)
  );

endmodule
`default_nettype wire

>>> tb/sv/bilinear_texture_sampler_checker.sv
// request/result checker of the bilinear texture sampler: predicts every result and compares
`default_nettype none
module bilinear_texture_sampler_checker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  input  wire logic                             in_stall,
  input  wire logic [2:0]                       mode,
  input  wire logic signed [15:0]               texel_x,
  input  wire logic signed [15:0]               texel_y,
  input  wire logic signed [23:0]               pos_x,
  input  wire logic signed [23:0]               pos_y,
  input  wire logic [15:0]                      red_in,
  input  wire logic [15:0]                      green_in,
  input  wire logic [15:0]                      blue_in,
  input  wire logic                             out_valid,
  input  wire logic                             out_stall,
  input  wire logic [15:0]                      red_out,
  input  wire logic [15:0]                      green_out,
  input  wire logic [15:0]                      blue_out,
  input  wire logic                             out_of_bounds,
  input  wire logic                             cfg_valid,
  input  wire logic                             cfg_ready,
  input  wire logic [bts_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [8:0]                       cfg_data,
  output int                                    fail_count,
  output int                                    outstanding,
  output int                                    checked_count
);
  import bts_pkg::*;

  localparam int SIDE_LOG2 = MAX_SIDE_LOG2_DEF;
  localparam int SIDE      = 1 << SIDE_LOG2;
  localparam int PIX_FB    = PIXEL_FRACTION_BITS_DEF;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        oob;
  } texel_result_t;

  logic [15:0]   srgb_to_linear [256];
  logic [47:0]   texels [1 << (2 * SIDE_LOG2)];
  int            width_eff;
  int            height_eff;
  texel_result_t expected_texels [$];

  initial begin
    logic [159:0] rhs;
    logic [159:0] lhs;
    int           n;
    n = 0;
    for (int i = 0; i < 256; i++) begin
      rhs = 160'd1;
      repeat (11) rhs = rhs * 160'(i);
      rhs = rhs << 65;
      while (n < 8192) begin
        lhs = 160'd1;
        repeat (5) lhs = lhs * 160'(2 * n + 1);
        repeat (11) lhs = lhs * 160'd255;
        if (lhs > rhs) break;
        n++;
      end
      srgb_to_linear[i] = 16'(n);
    end
  end

  function automatic int clamp_side(logic [8:0] v);
    if (v == 0) return 1;
    if (v > SIDE) return SIDE;
    return int'(v);
  endfunction

  function automatic bit in_texture(int x, int y);
    return x >= 0 && y >= 0 && x < width_eff && y < height_eff;
  endfunction

  function automatic logic [47:0] texel_at(int x, int y);
    if (!in_texture(x, y)) return 48'd0;
    return texels[y * SIDE + x];
  endfunction

  function automatic texel_result_t blend(int x0, int y0, longint unsigned fx,
                                          longint unsigned fy, int fb);
    longint unsigned one;
    longint unsigned w [4];
    longint unsigned acc [3];
    longint unsigned v;
    logic [47:0]     t;
    texel_result_t   r;
    one = longint'(1) << fb;
    w[0] = (one - fx) * (one - fy);
    w[1] = fx * (one - fy);
    w[2] = (one - fx) * fy;
    w[3] = fx * fy;
    acc = '{0, 0, 0};
    for (int q = 0; q < 4; q++) begin
      t = texel_at(x0 + (q & 1), y0 + (q >> 1));
      for (int k = 0; k < 3; k++) acc[k] += longint'(t[47 - 16 * k -: 16]) * w[q];
    end
    r.oob = 1'b0;
    for (int k = 0; k < 3; k++) begin
      v = (acc[k] + (longint'(1) << (2 * fb - 1))) >> (2 * fb);
      if (v > 65535) v = 65535;
      if (k == 0) r.red = 16'(v);
      else if (k == 1) r.green = 16'(v);
      else r.blue = 16'(v);
    end
    return r;
  endfunction

  function automatic texel_result_t sample_texture();
    texel_result_t   r;
    int              tx;
    int              ty;
    logic [15:0]     u;
    logic [23:0]     vneg;
    longint unsigned sx;
    longint unsigned sy;
    logic [47:0]     t;
    r = '0;
    tx = int'(texel_x);
    ty = int'(texel_y);
    case (mode)
      MODE_WRITE_LIN, MODE_WRITE_SRGB: begin
        if (!in_texture(tx, ty)) r.oob = 1'b1;
        else if (mode == MODE_WRITE_LIN) texels[ty * SIDE + tx] = {red_in, green_in, blue_in};
        else texels[ty * SIDE + tx] = {srgb_to_linear[red_in[7:0]],
                                       srgb_to_linear[green_in[7:0]],
                                       srgb_to_linear[blue_in[7:0]]};
      end
      MODE_READ: begin
        r.oob = !in_texture(tx, ty);
        t = texel_at(tx, ty);
        {r.red, r.green, r.blue} = t;
      end
      MODE_PIXEL: begin
        r = blend(int'(pos_x >>> PIX_FB), int'(pos_y >>> PIX_FB),
                  longint'(pos_x[PIX_FB-1:0]), longint'(pos_y[PIX_FB-1:0]), PIX_FB);
      end
      MODE_UV: begin
        u = pos_x[15:0];
        vneg = -pos_y;
        sx = longint'(u) * longint'(width_eff);
        sy = longint'(vneg[15:0]) * longint'(height_eff);
        r = blend(int'(sx >> 16), int'(sy >> 16), sx & 64'hFFFF, sy & 64'hFFFF, 16);
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, field, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    texel_result_t e;
    if (rst) begin
      width_eff <= SIDE;
      height_eff <= SIDE;
      expected_texels.delete();
      fail_count = 0;
      checked_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TEX_WIDTH) width_eff <= clamp_side(cfg_data);
        else if (cfg_index == REG_TEX_HEIGHT) height_eff <= clamp_side(cfg_data);
      end
      if (in_valid && !in_stall) expected_texels.push_back(sample_texture());
      if (out_valid && !out_stall) begin
        checked_count <= checked_count + 1;
        if (expected_texels.size() == 0) begin
          $display("mismatch at %0t: result with no request waiting", $realtime);
          fail_count++;
        end else begin
          e = expected_texels.pop_front();
          if (red_out !== e.red) report_mismatch("red_out", red_out, e.red);
          if (green_out !== e.green) report_mismatch("green_out", green_out, e.green);
          if (blue_out !== e.blue) report_mismatch("blue_out", blue_out, e.blue);
          if (out_of_bounds !== e.oob) report_mismatch("out_of_bounds", out_of_bounds, e.oob);
        end
      end
    end
  end

  assign outstanding = expected_texels.size();

endmodule
`default_nettype wire

>>> tb/sv/bilinear_texture_sampler_test.sv
// stimulus, stall control and verdict of the bilinear texture sampler testbench
`default_nettype none
module bilinear_texture_sampler_test;
  import bts_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 12;

  typedef struct {
    logic [2:0]         mode;
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic [15:0]        r;
    logic [15:0]        g;
    logic [15:0]        b;
  } texel_req_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [2:0]             mode = MODE_READ;
  logic signed [15:0]     texel_x = '0;
  logic signed [15:0]     texel_y = '0;
  logic signed [23:0]     pos_x = '0;
  logic signed [23:0]     pos_y = '0;
  logic [15:0]            red_in = '0;
  logic [15:0]            green_in = '0;
  logic [15:0]            blue_in = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [15:0]            red_out;
  logic [15:0]            green_out;
  logic [15:0]            blue_out;
  logic                   out_of_bounds;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_TEX_WIDTH;
  logic [8:0]             cfg_data = '0;

  int fail_count;
  int outstanding;
  int checked_count;
  int idle_cycles = 0;
  int sent_count = 0;
  int size_count = 0;
  int cur_w = 256;
  int cur_h = 256;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  // texels that hold a known value
  bit written [1 << 16];

  always #5 clk = ~clk;

  bilinear_texture_sampler u_dut (.*);

  bilinear_texture_sampler_checker u_checker (.*);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  initial begin
    int n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (300) @(negedge clk);
        out_stall = 1'b0;
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        n = pick_gap();
        if (n == 0) n = 1;
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  task automatic send_req(texel_req_t q);
    int gap;
    gap = quiet ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    mode = q.mode;
    texel_x = q.tx;
    texel_y = q.ty;
    pos_x = q.px;
    pos_y = q.py;
    red_in = q.r;
    green_in = q.g;
    blue_in = q.b;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    sent_count++;
    if ((q.mode == MODE_WRITE_LIN || q.mode == MODE_WRITE_SRGB) &&
        q.tx >= 0 && q.ty >= 0 && q.tx < cur_w && q.ty < cur_h)
      written[int'(q.ty) * 256 + int'(q.tx)] = 1'b1;
  endtask

  function automatic texel_req_t make_req(logic [2:0] m, int x, int y, int px, int py,
                                          logic [15:0] r, logic [15:0] g, logic [15:0] b);
    texel_req_t q;
    q.mode = m;
    q.tx = 16'(x);
    q.ty = 16'(y);
    q.px = 24'(px);
    q.py = 24'(py);
    q.r = r;
    q.g = g;
    q.b = b;
    return q;
  endfunction

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [8:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_size(logic [8:0] w, logic [8:0] h);
    @(negedge clk);
    in_valid = 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(REG_TEX_WIDTH, w);
    write_reg(REG_TEX_HEIGHT, h);
    cur_w = (w == 0) ? 1 : (w > 256 ? 256 : int'(w));
    cur_h = (h == 0) ? 1 : (h > 256 ? 256 : int'(h));
    size_count++;
  endtask

  function automatic texel_req_t random_req();
    texel_req_t q;
    int         sel;
    sel = $urandom_range(0, 99);
    q.tx = 16'($urandom);
    q.ty = 16'($urandom);
    q.px = 24'($urandom);
    q.py = 24'($urandom);
    q.r = 16'($urandom);
    q.g = 16'($urandom);
    q.b = 16'($urandom);
    if (sel < 18) q.mode = MODE_WRITE_LIN;
    else if (sel < 33) q.mode = MODE_WRITE_SRGB;
    else if (sel < 53) q.mode = MODE_READ;
    else if (sel < 73) q.mode = MODE_PIXEL;
    else if (sel < 95) q.mode = MODE_UV;
    else q.mode = 3'($urandom_range(5, 7));
    if (q.mode <= MODE_READ && $urandom_range(0, 7) != 0) begin
      q.tx = 16'($urandom_range(0, cur_w + 3) - 2);
      q.ty = 16'($urandom_range(0, cur_h + 3) - 2);
    end else if (q.mode == MODE_PIXEL && $urandom_range(0, 7) != 0) begin
      q.px = 24'($urandom_range(0, (cur_w + 3) * 256) - 512);
      q.py = 24'($urandom_range(0, (cur_h + 3) * 256) - 512);
    end
    return q;
  endfunction

  task automatic run_phase(logic [8:0] w, logic [8:0] h, int count, bit long_hold);
    set_size(w, h);
    // fill only the texels of the new size that hold nothing yet
    for (int y = 0; y < cur_h; y++)
      for (int x = 0; x < cur_w; x++)
        if (!written[y * 256 + x])
          send_req(make_req($urandom_range(0, 1) ? MODE_WRITE_LIN : MODE_WRITE_SRGB, x, y,
                            0, 0, 16'($urandom), 16'($urandom), 16'($urandom)));
    quiet = 1'b1;
    for (int i = 0; i < count; i++) begin
      if (i == 25) quiet = 1'b0;
      if (long_hold && i == 40) hold_req = 1'b1;
      send_req(random_req());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset size: corners, gamma extremes, edges and unused modes
    send_req(make_req(MODE_WRITE_LIN, 0, 0, 0, 0, 16'h0000, 16'hFFFF, 16'h0000));
    send_req(make_req(MODE_WRITE_SRGB, 1, 0, 0, 0, 16'h00FF, 16'hFF00, 16'h0080));
    send_req(make_req(MODE_WRITE_LIN, 0, 1, 0, 0, 16'hFFFF, 16'h1234, 16'h8000));
    send_req(make_req(MODE_WRITE_SRGB, 1, 1, 0, 0, 16'h0001, 16'h00FE, 16'hFFFF));
    send_req(make_req(MODE_WRITE_LIN, 255, 255, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_req(make_req(MODE_READ, 0, 0, 0, 0, 0, 0, 0));
    send_req(make_req(MODE_READ, 1, 0, 0, 0, 0, 0, 0));
    send_req(make_req(MODE_READ, 255, 255, 0, 0, 0, 0, 0));
    send_req(make_req(MODE_WRITE_LIN, 256, 0, 0, 0, 16'h5555, 16'hAAAA, 16'h0F0F));
    send_req(make_req(MODE_WRITE_SRGB, -1, 5, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_req(make_req(MODE_WRITE_LIN, 0, 256, 0, 0, 16'h1111, 16'h2222, 16'h3333));
    send_req(make_req(MODE_WRITE_LIN, -32768, 32767, 0, 0, 16'hFFFF, 0, 0));
    send_req(make_req(MODE_READ, -1, 0, 0, 0, 0, 0, 0));
    send_req(make_req(MODE_READ, 32767, -32768, 0, 0, 0, 0, 0));
    send_req(make_req(MODE_PIXEL, 0, 0, -8388608, -8388608, 0, 0, 0));
    send_req(make_req(MODE_PIXEL, 0, 0, 8388607, 8388607, 0, 0, 0));
    send_req(make_req(MODE_PIXEL, 0, 0, 0, 0, 0, 0, 0));
    send_req(make_req(MODE_PIXEL, 0, 0, 128, 128, 0, 0, 0));
    send_req(make_req(MODE_PIXEL, 0, 0, 255 * 256 + 128, 255 * 256 + 128, 0, 0, 0));
    send_req(make_req(MODE_UV, 0, 0, 0, 0, 0, 0, 0));
    send_req(make_req(MODE_UV, 0, 0, 24'h00FFFF, 1, 0, 0, 0));
    send_req(make_req(MODE_UV, 0, 0, 24'hFF0000, 24'h7F0000, 0, 0, 0));
    send_req(make_req(3'd5, 3, 3, 100, 100, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_req(make_req(3'd6, 0, 0, 0, 0, 0, 0, 0));
    send_req(make_req(3'd7, -1, -1, -1, -1, 16'hFFFF, 16'hFFFF, 16'hFFFF));

    // sizes include both extremes and out-of-range register values
    run_phase(9'd1, 9'd1, 40, 1'b0);
    run_phase(9'd4, 9'd3, 50, 1'b0);
    run_phase(9'd256, 9'd1, 70, 1'b1);
    run_phase(9'd1, 9'd256, 50, 1'b0);
    run_phase(9'd0, 9'd0, 30, 1'b0);
    run_phase(9'd511, 9'd1, 50, 1'b0);
    run_phase(9'd7, 9'd5, 50, 1'b0);

    @(negedge clk);
    in_valid = 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d requests over %0d texture sizes, %0d results checked",
             sent_count, size_count, checked_count);
    $display("writes, reads and samples mixed with random stalls and one long output hold");
    if (fail_count == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
